FILE: hdl/mks_pkg.sv
package mks_pkg;

  localparam int SPEED_W = 16;
  localparam int CHAR_W  = 8;
  localparam int TICKS_W = 24;
  localparam int UNITS_W = 3;
  localparam int CODE_W  = 6;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd100;

  localparam logic [CODE_W-1:0] CODE_NONE = 6'd1;

  localparam logic [UNITS_W-1:0] UNITS_DOT  = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_DASH = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_EGAP = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_LGAP = 3'd2;
  localparam logic [UNITS_W-1:0] UNITS_WGAP = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;
  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

  typedef enum logic [2:0] {
    KIND_DOT  = 3'd0,
    KIND_DASH = 3'd1,
    KIND_EGAP = 3'd2,
    KIND_LGAP = 3'd3,
    KIND_WGAP = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM,
    ST_EGAP,
    ST_LGAP,
    ST_WGAP
  } state_t;

  // element codes, first element in bit 0, 1 = dash, marker bit above the last
  localparam logic [CODE_W-1:0] LETTER_CODES [26] = '{
    6'd6,  6'd17, 6'd21, 6'd9,  6'd2,  6'd20, 6'd11, 6'd16, 6'd4,
    6'd30, 6'd13, 6'd18, 6'd7,  6'd5,  6'd15, 6'd22, 6'd27, 6'd10,
    6'd8,  6'd3,  6'd12, 6'd24, 6'd14, 6'd25, 6'd29, 6'd19
  };

  localparam logic [CODE_W-1:0] DIGIT_CODES [10] = '{
    6'd63, 6'd62, 6'd60, 6'd56, 6'd48, 6'd32, 6'd33, 6'd35, 6'd39, 6'd47
  };

  function automatic logic [CODE_W-1:0] morse_lookup(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [CHAR_W-1:0] li;
    logic [CHAR_W-1:0] di;
    u = c;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      u = c - CASE_BIT;
    end
    li = u - CHAR_UA;
    di = u - CHAR_D0;
    if (u >= CHAR_UA && u <= CHAR_UZ) begin
      morse_lookup = LETTER_CODES[li[4:0]];
    end else if (u >= CHAR_D0 && u <= CHAR_D9) begin
      morse_lookup = DIGIT_CODES[di[3:0]];
    end else begin
      morse_lookup = CODE_NONE;
    end
  endfunction

endpackage

FILE: hdl/mks_tick_scale.sv
module mks_tick_scale import mks_pkg::*; #(
  parameter int TICKS_PER_MS = 36
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SPEED_W-1:0] cfg_wdata,
  input  logic [UNITS_W-1:0] units,
  output logic [TICKS_W-1:0] ticks
);

  localparam int TPM_W = $clog2(TICKS_PER_MS + 1);
  localparam int UT_W  = SPEED_W + TPM_W;
  localparam int SC_W  = UT_W + 2;
  localparam int EXT_W = (SC_W > TICKS_W) ? SC_W : TICKS_W + 1;

  logic [UT_W-1:0]  unit_ticks;
  logic [SC_W-1:0]  scaled;
  logic [EXT_W-1:0] scaled_ext;

  // hold one unit in ticks, product taken at the write
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UT_W'(SPEED_RESET) * UT_W'(TICKS_PER_MS);
    end else if (cfg_we) begin
      unit_ticks <= UT_W'(cfg_wdata) * UT_W'(TICKS_PER_MS);
    end
  end

  always_comb begin
    case (units)
      3'd2:    scaled = {SC_W'(unit_ticks)} << 1;
      3'd3:    scaled = SC_W'(unit_ticks) + (SC_W'(unit_ticks) << 1);
      3'd4:    scaled = {SC_W'(unit_ticks)} << 2;
      default: scaled = SC_W'(unit_ticks);
    endcase
    scaled_ext = EXT_W'(scaled);
    if (|scaled_ext[EXT_W-1:TICKS_W]) begin
      ticks = '1;
    end else begin
      ticks = scaled_ext[TICKS_W-1:0];
    end
  end

endmodule

FILE: hdl/morse_keyer_sequencer_top.sv
// Morse keyer sequencer. Each accepted ASCII byte yields its key-line elements
// in order, one beat per element: dots and dashes each followed by an element
// gap, then a closing letter gap; space or tab yields a single word gap and any
// other byte only the letter gap. A character yields 1 to 11 elements after
// its accept; the code is shifted out one symbol at a time, as the output
// advances, from a small shift register behind the output register.
// length_ticks is units times speed_ms times TICKS_PER_MS, saturating at all
// ones; the per-unit product is formed when speed_ms is written, and a write
// applies to every element loaded after it.
module morse_keyer_sequencer_top import mks_pkg::*; #(
  parameter int TICKS_PER_MS = 36
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SPEED_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAR_W-1:0]  ascii_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               key_on,
  output logic [2:0]         element_kind,
  output logic [UNITS_W-1:0] length_units,
  output logic [TICKS_W-1:0] length_ticks,
  output logic               last_element
);

  state_t              state;
  state_t              state_next;
  logic [CODE_W-1:0]   code_sr;
  logic [CODE_W-1:0]   code_sr_next;
  logic [CODE_W-1:0]   code_in;
  logic                advance;
  kind_t               kind;
  logic [UNITS_W-1:0]  units;
  logic                last;
  logic [TICKS_W-1:0]  ticks;

  mks_tick_scale #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .units    (units),
    .ticks    (ticks)
  );

  assign in_ready = (state == ST_IDLE);
  assign advance  = (state != ST_IDLE) && (!out_valid || out_ready);
  assign code_in  = morse_lookup(ascii_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    code_sr <= code_sr_next;
  end

  always_comb begin
    state_next   = state;
    code_sr_next = code_sr;
    kind         = KIND_LGAP;
    units        = UNITS_LGAP;
    last         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          code_sr_next = code_in;
          if (ascii_char == CHAR_SPACE || ascii_char == CHAR_TAB) begin
            state_next = ST_WGAP;
          end else if (code_in == CODE_NONE) begin
            state_next = ST_LGAP;
          end else begin
            state_next = ST_SYM;
          end
        end
      end
      ST_SYM: begin
        kind  = code_sr[0] ? KIND_DASH : KIND_DOT;
        units = code_sr[0] ? UNITS_DASH : UNITS_DOT;
        if (advance) begin
          code_sr_next = code_sr >> 1;
          state_next   = ST_EGAP;
        end
      end
      ST_EGAP: begin
        kind  = KIND_EGAP;
        units = UNITS_EGAP;
        if (advance) begin
          state_next = (code_sr == CODE_NONE) ? ST_LGAP : ST_SYM;
        end
      end
      ST_LGAP: begin
        kind  = KIND_LGAP;
        units = UNITS_LGAP;
        last  = 1'b1;
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      ST_WGAP: begin
        kind  = KIND_WGAP;
        units = UNITS_WGAP;
        last  = 1'b1;
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load the next element into the output beat
  always_ff @(posedge clk) begin
    if (advance) begin
      key_on       <= (kind == KIND_DOT) || (kind == KIND_DASH);
      element_kind <= kind;
      length_units <= units;
      length_ticks <= ticks;
      last_element <= last;
    end
  end

endmodule
